@@ rtl/mnpe_pkg.sv @@
// ----------------------------------------------------------------------------
// mnpe_pkg
// Shared types and constants of the MIDI note pairing engine.
// ----------------------------------------------------------------------------
package mnpe_pkg;

  // Default depth of the open note table.
  localparam int unsigned OpenNotesDefault = 32;

  // Configuration register indexes.
  localparam logic [2:0] CfgClipStart = 3'd0;
  localparam logic [2:0] CfgMinDur    = 3'd1;
  localparam logic [2:0] CfgShortDur  = 3'd2;
  localparam logic [2:0] CfgOrphanDur = 3'd3;

  // Result kinds.
  localparam logic [1:0] KindNote    = 2'd0;
  localparam logic [1:0] KindClipLen = 2'd1;
  localparam logic [1:0] KindDropped = 2'd2;

  // One bar of four beats in Q16.16 is 2^18.
  localparam int unsigned BarShift = 18;

  // Command classes that the front hands to the back.
  typedef enum logic [1:0] {
    CmdNoteOn  = 2'd0,
    CmdNoteOff = 2'd1,
    CmdFlush   = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic signed [31:0] beat;
    logic [6:0]         pitch;
    logic [6:0]         velocity;
    logic [4:0]         channel;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] clip_start;
    logic [15:0]        min_dur;
    logic [31:0]        short_dur;
    logic [31:0]        orphan_dur;
  } cfg_t;

  // Handshake between the queue and the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

endpackage

@@ rtl/mnpe_front.sv @@
// ----------------------------------------------------------------------------
// mnpe_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mnpe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                op_i,
  input  logic signed [31:0]  event_beat_i,
  input  logic [6:0]          pitch_i,
  input  logic [6:0]          velocity_i,
  input  logic [4:0]          channel_i,
  output mnpe_pkg::queue_out_t q_o,
  input  logic                pop_i
);
  import mnpe_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       push, pop;

  // Classify the incoming word.
  always_comb begin
    cmd_in.beat     = event_beat_i;
    cmd_in.pitch    = pitch_i;
    cmd_in.velocity = velocity_i;
    cmd_in.channel  = channel_i;
    if (op_i) begin
      cmd_in.kind = CmdFlush;
    end else if (velocity_i != 7'd0) begin
      cmd_in.kind = CmdNoteOn;
    end else begin
      cmd_in.kind = CmdNoteOff;
    end
  end

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o;
  assign pop       = pop_i && (cnt_q != 2'd0);
  assign q_o.valid = (cnt_q != 2'd0);
  assign q_o.cmd   = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

@@ rtl/mnpe_back.sv @@
// ----------------------------------------------------------------------------
// mnpe_back
// Carries out queued commands against the ordered open note table.
// ----------------------------------------------------------------------------
module mnpe_back #(
  parameter int unsigned OPEN_NOTES = mnpe_pkg::OpenNotesDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mnpe_pkg::cfg_t       cfg_i,
  input  mnpe_pkg::queue_out_t q_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [1:0]           kind_o,
  output logic [6:0]           note_pitch_o,
  output logic [6:0]           note_velocity_o,
  output logic signed [32:0]   start_offset_o,
  output logic [31:0]          length_beats_o,
  output logic                 last_o
);
  import mnpe_pkg::*;

  localparam int unsigned CW = $clog2(OPEN_NOTES + 1);
  localparam int unsigned IW = (OPEN_NOTES > 1) ? $clog2(OPEN_NOTES) : 1;

  typedef enum logic [2:0] {
    StIdle, StScan, StShift, StFlushEmit, StFlushLen
  } state_e;

  state_e             state_q;
  cmd_t               cur_q;
  logic [CW-1:0]      count_q;
  logic [IW-1:0]      idx_q;
  logic signed [31:0] latest_q;
  logic signed [33:0] mx_q;
  cmd_t               table_q [OPEN_NOTES];

  logic [CW-1:0]      idx_ext, idx_nxt, rd_addr;
  cmd_t               ent;
  logic signed [32:0] dur, ent_off;
  logic [31:0]        dur_len;
  logic signed [33:0] orphan_end;
  logic signed [34:0] raw, rnd;
  logic [31:0]        clip_len;
  logic               match;

  // Table read at one address: the scan entry, or its successor when shifting.
  assign idx_ext = CW'(idx_q);
  assign idx_nxt = idx_ext + CW'(1);
  assign rd_addr = (state_q == StShift) ? idx_nxt : idx_ext;
  assign ent     = table_q[rd_addr[IW-1:0]];
  assign pop_o   = (state_q == StIdle) && q_i.valid;

  // Note arithmetic.
  always_comb begin
    dur     = {cur_q.beat[31], cur_q.beat} - {ent.beat[31], ent.beat};
    ent_off = {ent.beat[31], ent.beat} - {cfg_i.clip_start[31], cfg_i.clip_start};
    if (dur < $signed({17'd0, cfg_i.min_dur})) begin
      dur_len = cfg_i.short_dur;
    end else begin
      dur_len = dur[31:0];
    end
    match      = (ent.pitch == cur_q.pitch) && (ent.channel == cur_q.channel);
    orphan_end = {{2{ent.beat[31]}}, ent.beat} + $signed({2'b00, cfg_i.orphan_dur});
  end

  // Clip length: span rounded up to whole bars, at least one bar, saturated.
  always_comb begin
    raw = {mx_q[33], mx_q} - {{3{cfg_i.clip_start[31]}}, cfg_i.clip_start};
    rnd = raw + 35'sd262143;
    if (raw[34] || (raw == 35'sd0)) begin
      clip_len = 32'd262144;
    end else if (rnd[34:32] != 3'd0) begin
      clip_len = 32'hFFFF_FFFF;
    end else begin
      clip_len = {rnd[31:BarShift], {BarShift{1'b0}}};
    end
  end

  // Sequencer with registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      cur_q           <= '0;
      count_q         <= '0;
      idx_q           <= '0;
      latest_q        <= '0;
      mx_q            <= '0;
      result_valid_o  <= 1'b0;
      kind_o          <= KindNote;
      note_pitch_o    <= '0;
      note_velocity_o <= '0;
      start_offset_o  <= '0;
      length_beats_o  <= '0;
      last_o          <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (q_i.valid) begin
            cur_q <= q_i.cmd;
            idx_q <= '0;
            case (q_i.cmd.kind)
              CmdNoteOn: begin
                if (count_q == CW'(OPEN_NOTES)) begin
                  result_valid_o  <= 1'b1;
                  kind_o          <= KindDropped;
                  note_pitch_o    <= q_i.cmd.pitch;
                  note_velocity_o <= q_i.cmd.velocity;
                  start_offset_o  <= {q_i.cmd.beat[31], q_i.cmd.beat}
                                   - {cfg_i.clip_start[31], cfg_i.clip_start};
                  length_beats_o  <= '0;
                  last_o          <= 1'b1;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              CmdNoteOff: begin
                if (count_q != '0) begin
                  state_q <= StScan;
                end
              end
              CmdFlush: begin
                mx_q    <= {{2{latest_q[31]}}, latest_q};
                state_q <= (count_q == '0) ? StFlushLen : StFlushEmit;
              end
              default: begin
                state_q <= StIdle;
              end
            endcase
          end
        end
        StScan: begin
          if (match) begin
            result_valid_o  <= 1'b1;
            kind_o          <= KindNote;
            note_pitch_o    <= ent.pitch;
            note_velocity_o <= ent.velocity;
            start_offset_o  <= ent_off;
            length_beats_o  <= dur_len;
            last_o          <= 1'b1;
            if (cur_q.beat > latest_q) begin
              latest_q <= cur_q.beat;
            end
            if (idx_nxt < count_q) begin
              state_q <= StShift;
            end else begin
              count_q <= count_q - CW'(1);
              state_q <= StIdle;
            end
          end else if (idx_nxt == count_q) begin
            state_q <= StIdle;
          end else begin
            idx_q <= idx_nxt[IW-1:0];
          end
        end
        StShift: begin
          // Close the gap one entry per cycle.
          if ((idx_nxt + CW'(1)) >= count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= StIdle;
          end else begin
            idx_q <= idx_nxt[IW-1:0];
          end
        end
        StFlushEmit: begin
          result_valid_o  <= 1'b1;
          kind_o          <= KindNote;
          note_pitch_o    <= ent.pitch;
          note_velocity_o <= ent.velocity;
          start_offset_o  <= ent_off;
          length_beats_o  <= cfg_i.orphan_dur;
          last_o          <= 1'b0;
          if (orphan_end > mx_q) begin
            mx_q <= orphan_end;
          end
          if (idx_nxt == count_q) begin
            state_q <= StFlushLen;
          end else begin
            idx_q <= idx_nxt[IW-1:0];
          end
        end
        StFlushLen: begin
          result_valid_o  <= 1'b1;
          kind_o          <= KindClipLen;
          note_pitch_o    <= '0;
          note_velocity_o <= '0;
          start_offset_o  <= '0;
          length_beats_o  <= clip_len;
          last_o          <= 1'b1;
          count_q         <= '0;
          latest_q        <= cfg_i.clip_start;
          state_q         <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Table storage: append at the fill count, shift down after a close.
  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && q_i.valid && (q_i.cmd.kind == CmdNoteOn)
        && (count_q != CW'(OPEN_NOTES))) begin
      table_q[count_q[IW-1:0]] <= q_i.cmd;
    end else if (state_q == StShift) begin
      table_q[idx_q] <= ent;
    end
  end

endmodule

@@ rtl/midi_note_pairing_engine.sv @@
// A word is registered in the front queue and waits there until the back is idle;
// a dropped note-on shows its result the cycle after the back takes it. A note-off
// scans the open table and closes the gap one entry per cycle. An end of take emits
// one word per open note, then the clip length word. The queue takes words back to
// back until two wait. Reset clears the table count, queue and registers; the
// receiver cannot stall.
// ----------------------------------------------------------------------------
// midi_note_pairing_engine
// Pairs MIDI note-on and note-off events into finished notes with durations.
// ----------------------------------------------------------------------------
module midi_note_pairing_engine #(
  parameter int unsigned OPEN_NOTES = mnpe_pkg::OpenNotesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic signed [31:0] event_beat_i,
  input  logic [6:0]         pitch_i,
  input  logic [6:0]         velocity_i,
  input  logic [4:0]         channel_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic [1:0]         kind_o,
  output logic [6:0]         note_pitch_o,
  output logic [6:0]         note_velocity_o,
  output logic signed [32:0] start_offset_o,
  output logic [31:0]        length_beats_o,
  output logic               last_o
);
  import mnpe_pkg::*;

  cfg_t       cfg_q;
  queue_out_t q;
  logic       pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clip_start <= '0;
      cfg_q.min_dur    <= 16'd656;
      cfg_q.short_dur  <= 32'd8192;
      cfg_q.orphan_dur <= 32'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgClipStart: cfg_q.clip_start <= cfg_data_i;
        CfgMinDur:    cfg_q.min_dur    <= cfg_data_i[15:0];
        CfgShortDur:  cfg_q.short_dur  <= cfg_data_i;
        CfgOrphanDur: cfg_q.orphan_dur <= cfg_data_i;
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  mnpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .event_beat_i (event_beat_i),
    .pitch_i      (pitch_i),
    .velocity_i   (velocity_i),
    .channel_i    (channel_i),
    .q_o          (q),
    .pop_i        (pop)
  );

  mnpe_back #(
    .OPEN_NOTES (OPEN_NOTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_i             (q),
    .pop_o           (pop),
    .result_valid_o  (result_valid_o),
    .kind_o          (kind_o),
    .note_pitch_o    (note_pitch_o),
    .note_velocity_o (note_velocity_o),
    .start_offset_o  (start_offset_o),
    .length_beats_o  (length_beats_o),
    .last_o          (last_o)
  );

endmodule

@@ rtl/mnpe_checker.sv @@
// ----------------------------------------------------------------------------
// mnpe_checker
// Port level checks of the note pairing engine, bound to the top level.
// ----------------------------------------------------------------------------
module mnpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_valid_o,
  input logic [1:0]  kind_o,
  input logic [6:0]  note_pitch_o,
  input logic [31:0] length_beats_o,
  input logic        last_o
);
  import mnpe_pkg::*;

  // No result word comes out of reset.
  a_no_result_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !result_valid_o) else $error("result right after reset");

  // Clip length and dropped words always end their command.
  a_final_kinds_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (kind_o == KindClipLen || kind_o == KindDropped) |-> last_o)
    else $error("clip length or drop without last");

  // A clip length is a whole number of bars, at least one, or saturated.
  a_clip_len_bars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KindClipLen |->
      note_pitch_o == 7'd0 && length_beats_o != 32'd0 &&
      (length_beats_o[17:0] == 18'd0 || length_beats_o == 32'hFFFF_FFFF))
    else $error("bad clip length word");

  // A dropped note carries no length.
  a_drop_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KindDropped |-> length_beats_o == 32'd0)
    else $error("dropped note with length");

endmodule

bind midi_note_pairing_engine mnpe_checker u_mnpe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .note_pitch_o   (note_pitch_o),
  .length_beats_o (length_beats_o),
  .last_o         (last_o)
);
